>>> src/omx_pkg.sv
// Shared widths, types and the quarter-wave sine table of the omni wheel mixer.
// No dependencies; used by omni_wheel_mixer_unit.
package omx_pkg;

  localparam int unsigned DUTY_LIMIT_DEF = 250;

  localparam int unsigned ANGLE_W    = 9;
  localparam int unsigned POWER_W    = 8;
  localparam int unsigned ROT_W      = 9;
  localparam int unsigned DUTY_W     = 8;
  localparam int unsigned TRIG_W     = 16;
  localparam int unsigned TBL_IDX_W  = 7;
  localparam int unsigned PROD_W     = POWER_W + TRIG_W;
  localparam int unsigned TERM_W     = 17;
  localparam int unsigned MAG_W      = 18;
  localparam int unsigned WHEEL_W    = MAG_W + 1;
  localparam int unsigned NUM_WHEELS = 4;

  // Wheel order inside the lanes
  localparam int unsigned WHEEL_FR = 0;
  localparam int unsigned WHEEL_FL = 1;
  localparam int unsigned WHEEL_BR = 2;
  localparam int unsigned WHEEL_BL = 3;

  typedef struct packed {
    logic              neg;
    logic [TRIG_W-1:0] mag;
  } trig_t;

  // sin(k deg) in Q1.15 for k = 0..90
  localparam logic [TRIG_W-1:0] QSINE [0:90] = '{
        16'd0,   16'd572,  16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
     16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
     16'd7927,  16'd8481,  16'd9032,  16'd9580, 16'd10126, 16'd10668, 16'd11207,
    16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
    16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
    16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
    16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
    16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
    16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
    16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
    16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
    16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
    16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
  };

  // Sine of deg (0..359) as magnitude and sign, folded onto the quarter wave
  function automatic trig_t sine_deg(input logic [ANGLE_W-1:0] deg);
    logic [ANGLE_W-1:0]   idx;
    logic [TBL_IDX_W-1:0] k;
    trig_t                res;
    res.neg = 1'b0;
    priority if (deg <= ANGLE_W'(90)) begin
      idx = deg;
    end else if (deg <= ANGLE_W'(180)) begin
      idx = ANGLE_W'(180) - deg;
    end else if (deg <= ANGLE_W'(270)) begin
      idx     = deg - ANGLE_W'(180);
      res.neg = 1'b1;
    end else begin
      idx     = ANGLE_W'(360) - deg;
      res.neg = 1'b1;
    end
    k       = idx[TBL_IDX_W-1:0];
    res.mag = (k <= TBL_IDX_W'(90)) ? QSINE[k] : '0;
    return res;
  endfunction

endpackage

>>> src/omni_wheel_mixer_unit.sv
// X-drive omni wheel mixer: heading, power and rotation to four wheel duties.
// Depends on omx_pkg and omx_div.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries angle_deg_i, power_cmd_i
//   and rotation_cmd_i; output channel (out_valid_o / out_ready_i) carries a
//   forward and a reverse duty for each of the four wheels, one result per
//   input transaction, in order.
//   min_pwm_i is written when min_pwm_we_i is high (deadband, reset 0);
//   write it only while no transaction is in flight.
//   The divider has Q = clog2(DUTY_LIMIT + 1) quotient stages. One transaction
//   enters per cycle while in_ready_o is high: six front stages (angle fold,
//   sine lookup, multiply, rotation add, magnitude, maximum and scale), the
//   divider stages and the output register each hold one transaction.
//   When the receiver stalls, the output register holds its result and
//   stages upstream keep filling empty slots; in_ready_o drops once every
//   stage holds a transaction.
//   Reset clears all valid bits and min_pwm; no result is pending after it.
module omni_wheel_mixer_unit #(
  parameter int unsigned DUTY_LIMIT = omx_pkg::DUTY_LIMIT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              min_pwm_we_i,
  input  logic [omx_pkg::DUTY_W-1:0]        min_pwm_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [omx_pkg::ANGLE_W-1:0]       angle_deg_i,
  input  logic [omx_pkg::POWER_W-1:0]       power_cmd_i,
  input  logic signed [omx_pkg::ROT_W-1:0]  rotation_cmd_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [omx_pkg::DUTY_W-1:0]        fr_forward_duty_o,
  output logic [omx_pkg::DUTY_W-1:0]        fr_reverse_duty_o,
  output logic [omx_pkg::DUTY_W-1:0]        fl_forward_duty_o,
  output logic [omx_pkg::DUTY_W-1:0]        fl_reverse_duty_o,
  output logic [omx_pkg::DUTY_W-1:0]        br_forward_duty_o,
  output logic [omx_pkg::DUTY_W-1:0]        br_reverse_duty_o,
  output logic [omx_pkg::DUTY_W-1:0]        bl_forward_duty_o,
  output logic [omx_pkg::DUTY_W-1:0]        bl_reverse_duty_o
);

  localparam int unsigned ANGLE_W = omx_pkg::ANGLE_W;
  localparam int unsigned POWER_W = omx_pkg::POWER_W;
  localparam int unsigned ROT_W   = omx_pkg::ROT_W;
  localparam int unsigned DUTY_W  = omx_pkg::DUTY_W;
  localparam int unsigned PROD_W  = omx_pkg::PROD_W;
  localparam int unsigned TERM_W  = omx_pkg::TERM_W;
  localparam int unsigned MAG_W   = omx_pkg::MAG_W;
  localparam int unsigned SW      = omx_pkg::WHEEL_W;
  localparam int unsigned NW_CNT  = omx_pkg::NUM_WHEELS;

  localparam int unsigned LIM_W  = $clog2(DUTY_LIMIT + 1);
  localparam int unsigned QUO_W  = LIM_W;
  localparam int unsigned DEN_W  = (MAG_W > LIM_W + 8) ? MAG_W : LIM_W + 8;
  localparam int unsigned NUM_W  = MAG_W + LIM_W;
  localparam int unsigned CMP_W  = (QUO_W > DUTY_W) ? QUO_W : DUTY_W;
  localparam logic [DEN_W-1:0] DEN_FIXED = DEN_W'(DUTY_LIMIT * 256);
  localparam logic [NUM_W-1:0] LIM_MUL   = NUM_W'(DUTY_LIMIT);

  logic [DUTY_W-1:0] min_pwm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_pwm_q <= '0;
    end else if (min_pwm_we_i) begin
      min_pwm_q <= min_pwm_i;
    end
  end

  // Stage enables: a stage loads when it is empty or its successor loads
  logic en1, en2, en3, en4, en5, en6, en_out, div_in_ready;
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, s6_v_q, out_v_q;

  assign en_out = !out_v_q || out_ready_i;
  assign en6    = !s6_v_q || div_in_ready;
  assign en5    = !s5_v_q || en6;
  assign en4    = !s4_v_q || en5;
  assign en3    = !s3_v_q || en4;
  assign en2    = !s2_v_q || en3;
  assign en1    = !s1_v_q || en2;
  assign in_ready_o = en1;

  // ---------------- Stage 1: clamp inputs, fold angle ----------------
  logic [ANGLE_W-1:0]      ang_r, sdeg, cdeg;
  logic [ANGLE_W:0]        ang45, cdeg90;
  logic [POWER_W-1:0]      p_d;
  logic signed [ROT_W-1:0] rot_d;

  always_comb begin
    ang_r  = (angle_deg_i >= ANGLE_W'(360)) ? angle_deg_i - ANGLE_W'(360) : angle_deg_i;
    ang45  = {1'b0, ang_r} + (ANGLE_W + 1)'(45);
    sdeg   = (ang45 >= (ANGLE_W + 1)'(360)) ? ANGLE_W'(ang45 - (ANGLE_W + 1)'(360))
                                            : ang45[ANGLE_W-1:0];
    cdeg90 = {1'b0, sdeg} + (ANGLE_W + 1)'(90);
    cdeg   = (cdeg90 >= (ANGLE_W + 1)'(360)) ? ANGLE_W'(cdeg90 - (ANGLE_W + 1)'(360))
                                             : cdeg90[ANGLE_W-1:0];
    p_d    = (32'(power_cmd_i) > DUTY_LIMIT) ? POWER_W'(DUTY_LIMIT) : power_cmd_i;
    priority if (int'(rotation_cmd_i) > int'(DUTY_LIMIT)) begin
      rot_d = ROT_W'(DUTY_LIMIT);
    end else if (int'(rotation_cmd_i) < -int'(DUTY_LIMIT)) begin
      rot_d = -ROT_W'(DUTY_LIMIT);
    end else begin
      rot_d = rotation_cmd_i;
    end
  end

  logic [POWER_W-1:0]      s1_p_q;
  logic [ROT_W-1:0]        s1_rot_q;
  logic [ANGLE_W-1:0]      s1_sdeg_q, s1_cdeg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en1) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_p_q    <= p_d;
      s1_rot_q  <= rot_d;
      s1_sdeg_q <= sdeg;
      s1_cdeg_q <= cdeg;
    end
  end

  // ---------------- Stage 2: sine and cosine lookup ----------------
  omx_pkg::trig_t s2_sin_q, s2_cos_q;
  logic [POWER_W-1:0] s2_p_q;
  logic [ROT_W-1:0]   s2_rot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en2) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_sin_q <= omx_pkg::sine_deg(s1_sdeg_q);
      s2_cos_q <= omx_pkg::sine_deg(s1_cdeg_q);
      s2_p_q   <= s1_p_q;
      s2_rot_q <= s1_rot_q;
    end
  end

  // ---------------- Stage 3: translation terms ----------------
  logic [PROD_W-1:0] prod_s, prod_c;

  assign prod_s = PROD_W'(s2_p_q) * PROD_W'(s2_sin_q.mag) + PROD_W'(64);
  assign prod_c = PROD_W'(s2_p_q) * PROD_W'(s2_cos_q.mag) + PROD_W'(64);

  logic [TERM_W-1:0] s3_smag_q, s3_cmag_q;
  logic              s3_sneg_q, s3_cneg_q;
  logic [ROT_W-1:0]  s3_rot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en3) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_smag_q <= prod_s[PROD_W-1:7];
      s3_cmag_q <= prod_c[PROD_W-1:7];
      s3_sneg_q <= s2_sin_q.neg;
      s3_cneg_q <= s2_cos_q.neg;
      s3_rot_q  <= s2_rot_q;
    end
  end

  // ---------------- Stage 4: signed wheel powers plus rotation ----------------
  logic signed [SW-1:0] t_s, t_c, rot_w;
  logic [NW_CNT-1:0][SW-1:0] w_d;

  always_comb begin
    t_s   = $signed({{(SW - TERM_W){1'b0}}, s3_smag_q});
    t_c   = $signed({{(SW - TERM_W){1'b0}}, s3_cmag_q});
    t_s   = s3_sneg_q ? -t_s : t_s;
    t_c   = s3_cneg_q ? -t_c : t_c;
    rot_w = $signed({{(SW - ROT_W - 8){s3_rot_q[ROT_W-1]}}, s3_rot_q, 8'b0});
    w_d[omx_pkg::WHEEL_FR] = t_c + rot_w;
    w_d[omx_pkg::WHEEL_FL] = t_s + rot_w;
    w_d[omx_pkg::WHEEL_BR] = rot_w - t_s;
    w_d[omx_pkg::WHEEL_BL] = rot_w - t_c;
  end

  logic [NW_CNT-1:0][SW-1:0] s4_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (en4) begin
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      s4_w_q <= w_d;
    end
  end

  // ---------------- Stage 5: magnitudes and signs ----------------
  logic [NW_CNT-1:0][MAG_W-1:0] abs_d;
  logic [NW_CNT-1:0]            pos_d;
  logic [SW-1:0]                neg_w;

  always_comb begin
    for (int k = 0; k < NW_CNT; k++) begin
      neg_w    = -s4_w_q[k];
      abs_d[k] = s4_w_q[k][SW-1] ? neg_w[MAG_W-1:0] : s4_w_q[k][MAG_W-1:0];
      pos_d[k] = !s4_w_q[k][SW-1] && (s4_w_q[k] != '0);
    end
  end

  logic [NW_CNT-1:0][MAG_W-1:0] s5_abs_q;
  logic [NW_CNT-1:0]            s5_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
    end else if (en5) begin
      s5_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      s5_abs_q <= abs_d;
      s5_pos_q <= pos_d;
    end
  end

  // ---------------- Stage 6: maximum, divisor, scaled numerators ----------------
  // Unscaled wheels use divisor LIMIT << 8, which gives |w| >> 8 exactly
  logic [MAG_W-1:0]             max01, max23, max_all;
  logic [DEN_W-1:0]             den_d;
  logic [NW_CNT-1:0][NUM_W-1:0] num_d;

  always_comb begin
    max01   = (s5_abs_q[0] > s5_abs_q[1]) ? s5_abs_q[0] : s5_abs_q[1];
    max23   = (s5_abs_q[2] > s5_abs_q[3]) ? s5_abs_q[2] : s5_abs_q[3];
    max_all = (max01 > max23) ? max01 : max23;
    den_d   = (DEN_W'(max_all) > DEN_FIXED) ? DEN_W'(max_all) : DEN_FIXED;
    for (int k = 0; k < NW_CNT; k++) begin
      num_d[k] = NUM_W'(s5_abs_q[k]) * LIM_MUL;
    end
  end

  logic [NW_CNT-1:0][NUM_W-1:0] s6_num_q;
  logic [DEN_W-1:0]             s6_den_q;
  logic [NW_CNT-1:0]            s6_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_v_q <= 1'b0;
    end else if (en6) begin
      s6_v_q <= s5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en6) begin
      s6_num_q <= num_d;
      s6_den_q <= den_d;
      s6_pos_q <= s5_pos_q;
    end
  end

  // ---------------- Divider ----------------
  logic                         div_out_valid;
  logic [NW_CNT-1:0][QUO_W-1:0] div_quo;
  logic [NW_CNT-1:0]            div_pos;

  omx_div #(
    .LANES (NW_CNT),
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .QUO_W (QUO_W),
    .TAG_W (NW_CNT)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s6_v_q),
    .in_ready_o  (div_in_ready),
    .num_i       (s6_num_q),
    .den_i       (s6_den_q),
    .tag_i       (s6_pos_q),
    .out_valid_o (div_out_valid),
    .out_ready_i (en_out),
    .quo_o       (div_quo),
    .tag_o       (div_pos)
  );

  // ---------------- Output: deadband and direction split ----------------
  // The quotient never exceeds the limit, so no clamp is needed here
  logic [NW_CNT-1:0][DUTY_W-1:0] fwd_d, rev_d;
  logic [CMP_W-1:0]              q_ext;
  logic [DUTY_W-1:0]             duty;

  always_comb begin
    for (int k = 0; k < NW_CNT; k++) begin
      q_ext = CMP_W'(div_quo[k]);
      duty  = (q_ext < CMP_W'(min_pwm_q)) ? '0 : q_ext[DUTY_W-1:0];
      fwd_d[k] = div_pos[k] ? duty : '0;
      rev_d[k] = div_pos[k] ? '0 : duty;
    end
  end

  logic [NW_CNT-1:0][DUTY_W-1:0] fwd_q, rev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_out) begin
      out_v_q <= div_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      fwd_q <= fwd_d;
      rev_q <= rev_d;
    end
  end

  assign out_valid_o       = out_v_q;
  assign fr_forward_duty_o = fwd_q[omx_pkg::WHEEL_FR];
  assign fr_reverse_duty_o = rev_q[omx_pkg::WHEEL_FR];
  assign fl_forward_duty_o = fwd_q[omx_pkg::WHEEL_FL];
  assign fl_reverse_duty_o = rev_q[omx_pkg::WHEEL_FL];
  assign br_forward_duty_o = fwd_q[omx_pkg::WHEEL_BR];
  assign br_reverse_duty_o = rev_q[omx_pkg::WHEEL_BR];
  assign bl_forward_duty_o = fwd_q[omx_pkg::WHEEL_BL];
  assign bl_reverse_duty_o = rev_q[omx_pkg::WHEEL_BL];

  // ---------------- Assertions ----------------
  // A wheel never drives both directions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((fr_forward_duty_o == '0) || (fr_reverse_duty_o == '0)) &&
                    ((fl_forward_duty_o == '0) || (fl_reverse_duty_o == '0)) &&
                    ((br_forward_duty_o == '0) || (br_reverse_duty_o == '0)) &&
                    ((bl_forward_duty_o == '0) || (bl_reverse_duty_o == '0)))
    else $error("wheel drives forward and reverse at once");

  // Scaling keeps every duty within the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (DUTY_LIMIT < 256)) |->
      (32'(fr_forward_duty_o) <= DUTY_LIMIT) && (32'(fr_reverse_duty_o) <= DUTY_LIMIT) &&
      (32'(fl_forward_duty_o) <= DUTY_LIMIT) && (32'(fl_reverse_duty_o) <= DUTY_LIMIT) &&
      (32'(br_forward_duty_o) <= DUTY_LIMIT) && (32'(br_reverse_duty_o) <= DUTY_LIMIT) &&
      (32'(bl_forward_duty_o) <= DUTY_LIMIT) && (32'(bl_reverse_duty_o) <= DUTY_LIMIT))
    else $error("duty above limit");

  // The divisor handed to the divider is never zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s6_v_q |-> (s6_den_q != '0))
    else $error("zero divisor entering divider");

  // A stalled output register holds its result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_ready_i) |=> (out_v_q && $stable(fwd_q) && $stable(rev_q)))
    else $error("output result changed while stalled");

endmodule

>>> src/omx_div.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor. Depends on nothing but its parameters.
module omx_div #(
  parameter int unsigned LANES = 4,
  parameter int unsigned NUM_W = 26,
  parameter int unsigned DEN_W = 18,
  parameter int unsigned QUO_W = 8,
  parameter int unsigned TAG_W = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [LANES-1:0][NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]             den_i,
  input  logic [TAG_W-1:0]             tag_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [LANES-1:0][QUO_W-1:0]  quo_o,
  output logic [TAG_W-1:0]             tag_o
);

  // Numerator must stay below den << QUO_W, so the remainder fits here
  localparam int unsigned REM_W = DEN_W + QUO_W;

  logic [QUO_W:0]                   en;
  logic [QUO_W-1:0]                 v_q;
  logic [LANES-1:0][REM_W-1:0]      rem_q [QUO_W];
  logic [LANES-1:0][QUO_W-1:0]      quo_q [QUO_W];
  logic [DEN_W-1:0]                 den_q [QUO_W];
  logic [TAG_W-1:0]                 tag_q [QUO_W];

  assign en[QUO_W] = out_ready_i;
  assign in_ready_o = en[0];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    localparam int unsigned BIT = QUO_W - 1 - s;

    logic                        v_in;
    logic [LANES-1:0][REM_W-1:0] rem_in;
    logic [LANES-1:0][QUO_W-1:0] quo_in;
    logic [DEN_W-1:0]            den_in;
    logic [TAG_W-1:0]            tag_in;
    logic [LANES-1:0][REM_W-1:0] rem_d;
    logic [LANES-1:0][QUO_W-1:0] quo_d;
    logic [REM_W-1:0]            shifted;

    if (s == 0) begin : g_first
      assign v_in   = in_valid_i;
      assign den_in = den_i;
      assign tag_in = tag_i;
      assign quo_in = '0;
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign rem_in[l] = REM_W'(num_i[l]);
      end
    end else begin : g_next
      assign v_in   = v_q[s-1];
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
      assign den_in = den_q[s-1];
      assign tag_in = tag_q[s-1];
    end

    assign en[s]   = !v_q[s] || en[s+1];
    assign shifted = REM_W'(den_in) << BIT;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        if (rem_in[l] >= shifted) begin
          rem_d[l] = rem_in[l] - shifted;
          quo_d[l] = quo_in[l] | (QUO_W'(1) << BIT);
        end else begin
          rem_d[l] = rem_in[l];
          quo_d[l] = quo_in[l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en[s]) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[s]) begin
        rem_q[s] <= rem_d;
        quo_q[s] <= quo_d;
        den_q[s] <= den_in;
        tag_q[s] <= tag_in;
      end
    end
  end

  assign out_valid_o = v_q[QUO_W-1];
  assign quo_o       = quo_q[QUO_W-1];
  assign tag_o       = tag_q[QUO_W-1];

endmodule
